FILE: design/simon_pkg.sv
// ----------------------------------------------------------------------------
// simon_pkg: shared types, constants and functions
// Round count, key schedule constants, round function and the control
// types used between the sequencer and the datapath parts.
// ----------------------------------------------------------------------------
package simon_pkg;

    localparam int unsigned ROUND_COUNT = 68;
    localparam int unsigned Z_PERIOD    = 62;
    localparam int unsigned WORD_W      = 64;
    localparam int unsigned RK_IDX_W    = $clog2(ROUND_COUNT);
    localparam int unsigned CNT_W       = $clog2(ROUND_COUNT + 1);

    localparam logic [WORD_W-1:0] SCHED_CONST = 64'hFFFF_FFFF_FFFF_FFFC;
    localparam logic [WORD_W-1:0] Z_SEQ       = 64'h3369_F885_192C_0EF5;

    localparam logic [RK_IDX_W-1:0] LAST_RK = RK_IDX_W'(ROUND_COUNT - 1);
    localparam logic [CNT_W-1:0]    CNT_LAST_RK = CNT_W'(ROUND_COUNT - 1);
    localparam logic [CNT_W-1:0]    CNT_ROUNDS  = CNT_W'(ROUND_COUNT);

    localparam logic [1:0] CFG_KEY_FIRST  = 2'd0;
    localparam logic [1:0] CFG_KEY_SECOND = 2'd1;

    typedef logic [WORD_W-1:0] word_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_ROUNDS,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic decrypt;
    } round_ctrl_t;

    typedef struct packed {
        logic load;
        logic advance;
    } sched_ctrl_t;

    function automatic word_t rotl(input word_t x, input int unsigned r);
        rotl = (x << r) | (x >> (WORD_W - r));
    endfunction

    function automatic word_t rotr(input word_t x, input int unsigned r);
        rotr = (x >> r) | (x << (WORD_W - r));
    endfunction

    function automatic word_t round_fn(input word_t x);
        round_fn = (rotl(x, 1) & rotl(x, 8)) ^ rotl(x, 2);
    endfunction

    function automatic logic z_bit(input logic [CNT_W-1:0] step);
        logic [CNT_W-1:0] idx;
        idx = (step >= CNT_W'(Z_PERIOD)) ? (step - CNT_W'(Z_PERIOD)) : step;
        z_bit = Z_SEQ[idx[5:0]];
    endfunction

endpackage

FILE: design/simon_rk_ram.sv
// ----------------------------------------------------------------------------
// simon_rk_ram: round key store
// One write port and one registered read port over the round key words.
// ----------------------------------------------------------------------------
module simon_rk_ram (
    input  logic                            clk,
    input  logic                            we,
    input  logic [simon_pkg::RK_IDX_W-1:0]  waddr,
    input  simon_pkg::word_t                wdata,
    input  logic                            re,
    input  logic [simon_pkg::RK_IDX_W-1:0]  raddr,
    output simon_pkg::word_t                rdata
);

    simon_pkg::word_t mem [simon_pkg::ROUND_COUNT];
    simon_pkg::word_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/simon_key_sched.sv
// ----------------------------------------------------------------------------
// simon_key_sched: key expansion step unit
// Holds the two running schedule words and advances them one round key
// per cycle while advance is set; low word is the current step's round key.
// ----------------------------------------------------------------------------
module simon_key_sched (
    input  logic                         clk,
    input  simon_pkg::sched_ctrl_t       ctrl,
    input  simon_pkg::word_t             key_first,
    input  simon_pkg::word_t             key_second,
    input  logic [simon_pkg::CNT_W-1:0]  step,
    output simon_pkg::word_t             round_key
);

    simon_pkg::word_t lo_reg, lo_next;
    simon_pkg::word_t hi_reg, hi_next;
    simon_pkg::word_t t;

    always_comb
    begin
        t       = simon_pkg::rotr(hi_reg, 3);
        lo_next = lo_reg;
        hi_next = hi_reg;
        if (ctrl.load)
        begin
            lo_next = key_first;
            hi_next = key_second;
        end
        else if (ctrl.advance)
        begin
            lo_next = hi_reg;
            hi_next = lo_reg ^ t ^ simon_pkg::rotr(t, 1) ^ simon_pkg::SCHED_CONST
                      ^ simon_pkg::word_t'(simon_pkg::z_bit(step));
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
    end

    assign round_key = lo_reg;

endmodule

FILE: design/simon_round.sv
// ----------------------------------------------------------------------------
// simon_round: shared Feistel round unit
// Holds both block halves and applies one forward or inverse round per
// cycle while step is set, with the supplied round key.
// ----------------------------------------------------------------------------
module simon_round (
    input  logic                    clk,
    input  simon_pkg::round_ctrl_t  ctrl,
    input  simon_pkg::word_t        load_right,
    input  simon_pkg::word_t        load_left,
    input  simon_pkg::word_t        round_key,
    output simon_pkg::word_t        right,
    output simon_pkg::word_t        left
);

    simon_pkg::word_t right_reg, right_next;
    simon_pkg::word_t left_reg, left_next;

    always_comb
    begin
        right_next = right_reg;
        left_next  = left_reg;
        if (ctrl.load)
        begin
            right_next = load_right;
            left_next  = load_left;
        end
        else if (ctrl.step)
        begin
            if (ctrl.decrypt)
            begin
                left_next  = right_reg;
                right_next = simon_pkg::round_fn(right_reg) ^ left_reg ^ round_key;
            end
            else
            begin
                right_next = left_reg;
                left_next  = simon_pkg::round_fn(left_reg) ^ right_reg ^ round_key;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        right_reg <= right_next;
        left_reg  <= left_next;
    end

    assign right = right_reg;
    assign left  = left_reg;

endmodule

FILE: design/simon_128_128_block_cipher_unit.sv
// ----------------------------------------------------------------------------
// simon_128_128_block_cipher_unit: Simon 128/128 ECB cipher
// Sequencer, key registers and output word register around the key
// schedule unit, the round key store and the shared round unit.
// ----------------------------------------------------------------------------
// Usage:
//   Write the key through cfg_write/cfg_index/cfg_data while idle: index 0
//   is key word 0, index 1 key word 1; other indexes are dropped.
//   Input words (action, block halves) are taken when in_valid is high and
//   in_stall low; in_stall stays high while a word is in work.
//   The first word after reset or after a key write first expands the 68
//   round keys, one per cycle, into the round key store.
//   Each word then runs 68 rounds on one shared round unit, one round per
//   cycle, paced by the round key store's registered read port, then moves
//   the result to the output register.
//   The result waits in its output register while out_stall is high; the
//   next word may be accepted and run meanwhile, holding at the end until
//   the output register is free.
//   Reset clears the key registers to zero and marks the keys not ready.
// ----------------------------------------------------------------------------
module simon_128_128_block_cipher_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic [1:0]        cfg_index,
    input  logic [63:0]       cfg_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              action,
    input  logic [63:0]       block_word_right,
    input  logic [63:0]       block_word_left,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [63:0]       result_word_right,
    output logic [63:0]       result_word_left
);

    simon_pkg::state_t state_reg, state_next;
    logic [simon_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic action_reg, action_next;
    logic keys_ready_reg, keys_ready_next;
    logic out_valid_reg, out_valid_next;
    simon_pkg::word_t key_first_reg, key_first_next;
    simon_pkg::word_t key_second_reg, key_second_next;
    simon_pkg::word_t res_right_reg, res_left_reg;

    simon_pkg::round_ctrl_t round_ctrl;
    simon_pkg::sched_ctrl_t sched_ctrl;
    logic accept;
    logic out_load;
    logic ram_we;
    logic ram_re;
    logic [simon_pkg::RK_IDX_W-1:0] ram_raddr;
    simon_pkg::word_t sched_key;
    simon_pkg::word_t ram_rdata;
    simon_pkg::word_t dp_right, dp_left;

    assign in_stall = (state_reg != simon_pkg::ST_IDLE);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        state_next         = state_reg;
        cnt_next           = cnt_reg;
        action_next        = action_reg;
        keys_ready_next    = keys_ready_reg;
        key_first_next     = key_first_reg;
        key_second_next    = key_second_reg;
        round_ctrl.load    = 1'b0;
        round_ctrl.step    = 1'b0;
        round_ctrl.decrypt = action_reg;
        sched_ctrl.load    = 1'b0;
        sched_ctrl.advance = 1'b0;
        ram_we             = 1'b0;
        ram_re             = 1'b0;
        ram_raddr          = cnt_reg[simon_pkg::RK_IDX_W-1:0];
        out_load           = 1'b0;

        if (cfg_write)
        begin
            unique case (cfg_index)
                simon_pkg::CFG_KEY_FIRST:
                begin
                    key_first_next  = cfg_data;
                    keys_ready_next = 1'b0;
                end
                simon_pkg::CFG_KEY_SECOND:
                begin
                    key_second_next = cfg_data;
                    keys_ready_next = 1'b0;
                end
                default:
                begin
                end
            endcase
        end

        unique case (state_reg)
            simon_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    round_ctrl.load = 1'b1;
                    sched_ctrl.load = !keys_ready_reg;
                    action_next     = action;
                    cnt_next        = '0;
                    state_next      = keys_ready_reg ? simon_pkg::ST_ROUNDS
                                                     : simon_pkg::ST_EXPAND;
                end
            end
            simon_pkg::ST_EXPAND:
            begin
                ram_we             = 1'b1;
                sched_ctrl.advance = 1'b1;
                if (cnt_reg == simon_pkg::CNT_LAST_RK)
                begin
                    cnt_next        = '0;
                    keys_ready_next = 1'b1;
                    state_next      = simon_pkg::ST_ROUNDS;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            simon_pkg::ST_ROUNDS:
            begin
                ram_re          = (cnt_reg != simon_pkg::CNT_ROUNDS);
                ram_raddr       = action_reg
                                ? (simon_pkg::LAST_RK - cnt_reg[simon_pkg::RK_IDX_W-1:0])
                                : cnt_reg[simon_pkg::RK_IDX_W-1:0];
                round_ctrl.step = (cnt_reg != '0);
                if (cnt_reg == simon_pkg::CNT_ROUNDS)
                begin
                    state_next = simon_pkg::ST_FINISH;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            simon_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = simon_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = simon_pkg::ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= simon_pkg::ST_IDLE;
            cnt_reg        <= '0;
            action_reg     <= 1'b0;
            keys_ready_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            key_first_reg  <= '0;
            key_second_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            action_reg     <= action_next;
            keys_ready_reg <= keys_ready_next;
            out_valid_reg  <= out_valid_next;
            key_first_reg  <= key_first_next;
            key_second_reg <= key_second_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            res_right_reg <= dp_right;
            res_left_reg  <= dp_left;
        end
    end

    simon_key_sched u_key_sched (
        .clk        (clk),
        .ctrl       (sched_ctrl),
        .key_first  (key_first_reg),
        .key_second (key_second_reg),
        .step       (cnt_reg),
        .round_key  (sched_key)
    );

    simon_rk_ram u_rk_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cnt_reg[simon_pkg::RK_IDX_W-1:0]),
        .wdata (sched_key),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    simon_round u_round (
        .clk        (clk),
        .ctrl       (round_ctrl),
        .load_right (block_word_right),
        .load_left  (block_word_left),
        .round_key  (ram_rdata),
        .right      (dp_right),
        .left       (dp_left)
    );

    assign out_valid         = out_valid_reg;
    assign result_word_right = res_right_reg;
    assign result_word_left  = res_left_reg;

endmodule
